### src/lpl_pkg.sv
// Shared types and constants for the line plot to LCD bitmap block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package lpl_pkg;

    // Input field widths
    localparam int GROUP_W = 3;
    localparam int ROW_W   = 6;

    // Columns per render group
    localparam int GROUP_COLS = 16;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Item kinds carried on tuser
    localparam logic KIND_PLOT   = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic REG_SLOPE     = 1'b0;
    localparam logic REG_INTERCEPT = 1'b1;

    // Line equation constants, modulo 256
    localparam logic [7:0] T_OFFSET = 8'd31;

    // Serial framing
    localparam logic [7:0] SYNC_BYTE   = 8'hF8;
    localparam logic [7:0] ADDR_CMD    = 8'h80;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] AXIS_BYTE   = 8'hFF;
    localparam logic [7:0] HADDR_SPLIT = 8'd8;

    typedef struct packed {
        logic               kind;
        logic [GROUP_W-1:0] group;
        logic [ROW_W-1:0]   row;
    } cmd_t;

endpackage

### src/lpl_front.sv
// Front end: accepts input beats, turns them into commands and queues them.
// Depends on lpl_pkg.
`timescale 1ns / 1ps

module lpl_front (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [2:0] column_group, [8:3] row, rest zero
    input  logic         s_tuser,   // [0] kind
    output logic         cmd_valid,
    input  logic         cmd_ready,
    output lpl_pkg::cmd_t cmd
);
    import lpl_pkg::*;

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;
    cmd_t              cmd_in;

    assign s_tready  = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid & s_tready;
    assign pop       = cmd_valid & cmd_ready;

    always_comb
    begin
        cmd_in.kind  = s_tuser;
        cmd_in.group = s_tdata[GROUP_W-1:0];
        cmd_in.row   = s_tdata[GROUP_W+ROW_W-1:GROUP_W];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### src/lpl_col_store.sv
// Column position store: one memory row per 16-column group, with a valid
// bit per row so unwritten rows read as zero after reset. Depends on lpl_pkg.
`timescale 1ns / 1ps

module lpl_col_store #(
    parameter int GROUPS = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 96
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);
    import lpl_pkg::*;

    logic [DATA_W-1:0] mem [GROUPS];
    logic [GROUPS-1:0] valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= (int'(rd_addr) < GROUPS) ? valid_reg[rd_addr] : 1'b0;
            end
        end
    end

    // Unwritten rows hold the reset value of zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### src/lpl_back.sv
// Back end: regenerates the column positions and renders bitmap rows into
// framed serial bytes. Depends on lpl_pkg and lpl_col_store.
`timescale 1ns / 1ps

module lpl_back #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  lpl_pkg::cmd_t cmd,
    input  logic [7:0]    slope,
    input  logic [7:0]    intercept,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);
    import lpl_pkg::*;

    localparam int GROUPS = (COLUMNS + GROUP_COLS - 1) / GROUP_COLS;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int POS_W  = $clog2(ROWS);
    localparam int HALF   = ROWS / 2;
    localparam int DATA_W = GROUP_COLS * POS_W;
    localparam int K_W    = $clog2(GROUP_COLS);

    localparam logic [1:0] FR_VADDR = 2'd0;
    localparam logic [1:0] FR_HADDR = 2'd1;
    localparam logic [1:0] FR_HI    = 2'd2;
    localparam logic [1:0] FR_LO    = 2'd3;

    localparam logic [1:0] SUB_SYNC = 2'd0;
    localparam logic [1:0] SUB_HIGH = 2'd1;
    localparam logic [1:0] SUB_LOW  = 2'd2;

    typedef logic [GROUP_COLS-1:0][POS_W-1:0] row_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLOT,
        S_BUILD,
        S_SEND
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [7:0]        t_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [K_W-1:0]    k_reg;
    row_t              buf_reg;
    row_t              buf_next;
    logic [7:0]        hi_reg;
    logic [7:0]        lo_reg;
    logic [1:0]        frame_reg;
    logic [1:0]        sub_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;

    logic [7:0]        t_start;
    logic [7:0]        v;
    logic [POS_W-1:0]  pos;
    logic              wr_en;
    logic              rd_en;
    row_t              rd_row;
    logic [DATA_W-1:0] rd_data;
    logic [7:0]        hi_bits;
    logic [7:0]        lo_bits;
    logic              upper;
    logic [7:0]        vaddr;
    logic [7:0]        haddr;
    logic [7:0]        frame_data;
    logic              rs;
    logic [7:0]        byte_out;
    logic              out_free;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rd_en     = (state_reg == S_IDLE) && cmd_valid;
    assign wr_en     = (state_reg == S_PLOT) && (k_reg == K_W'(GROUP_COLS - 1));

    // Column 0 of the line sits at x = -63: t0 = b + 31 - 63*m, modulo 256
    assign t_start = intercept + T_OFFSET + slope - {slope[1:0], 6'b0};

    always_comb
    begin
        v   = 8'(ROWS - 1) - t_reg;
        pos = (v > 8'(ROWS - 1)) ? POS_W'(HALF) : POS_W'(v);
        buf_next        = buf_reg;
        buf_next[k_reg] = pos;
    end

    lpl_col_store #(
        .GROUPS (GROUPS),
        .ADDR_W (GRP_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (grp_reg),
        .wr_data (buf_next),
        .rd_en   (rd_en),
        .rd_addr (GRP_W'(cmd.group)),
        .rd_data (rd_data)
    );

    assign rd_row = rd_data;

    // Match each stored position against the row; drop columns past the end; the axis row sets every bit
    always_comb
    begin
        logic hit;
        hi_bits = '0;
        lo_bits = '0;
        for (int k = 0; k < GROUP_COLS; k++)
        begin
            hit = (9'({cmd_reg.group, 4'(k)}) < 9'(COLUMNS))
                  && (ROW_W'(rd_row[k]) == cmd_reg.row);
            if (k < 8)
            begin
                hi_bits[7 - k] = hit;
            end
            else
            begin
                lo_bits[15 - k] = hit;
            end
        end
        if (cmd_reg.row == ROW_W'(HALF))
        begin
            hi_bits = AXIS_BYTE;
            lo_bits = AXIS_BYTE;
        end
    end

    always_comb
    begin
        upper = (cmd_reg.row >= ROW_W'(HALF));
        vaddr = ADDR_CMD + (upper ? 8'(cmd_reg.row - ROW_W'(HALF)) : 8'(cmd_reg.row));
        haddr = ADDR_CMD + 8'(cmd_reg.group) + (upper ? HADDR_SPLIT : 8'd0);
        unique case (frame_reg)
            FR_VADDR: frame_data = vaddr;
            FR_HADDR: frame_data = haddr;
            FR_HI:    frame_data = hi_reg;
            FR_LO:    frame_data = lo_reg;
        endcase
        rs = (frame_reg == FR_HI) || (frame_reg == FR_LO);
        unique case (sub_reg)
            SUB_SYNC: byte_out = SYNC_BYTE | {6'b0, rs, 1'b0};
            SUB_HIGH: byte_out = frame_data & NIBBLE_MASK;
            SUB_LOW:  byte_out = {frame_data[3:0], 4'b0};
            default:  byte_out = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            t_reg        <= '0;
            grp_reg      <= '0;
            k_reg        <= '0;
            buf_reg      <= '0;
            hi_reg       <= '0;
            lo_reg       <= '0;
            frame_reg    <= FR_VADDR;
            sub_reg      <= SUB_SYNC;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            // Drop a taken beat unless a new one replaces it this cycle
            if (m_tready && !((state_reg == S_SEND) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg <= cmd;
                        t_reg   <= t_start;
                        grp_reg <= '0;
                        k_reg   <= '0;
                        state_reg <= (cmd.kind == KIND_PLOT) ? S_PLOT : S_BUILD;
                    end
                end
                S_PLOT:
                begin
                    buf_reg <= buf_next;
                    t_reg   <= t_reg + slope;
                    k_reg   <= k_reg + 1'b1;
                    if (wr_en)
                    begin
                        if (grp_reg == GRP_W'(GROUPS - 1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            grp_reg <= grp_reg + 1'b1;
                        end
                    end
                end
                S_BUILD:
                begin
                    hi_reg    <= hi_bits;
                    lo_reg    <= lo_bits;
                    frame_reg <= FR_VADDR;
                    sub_reg   <= SUB_SYNC;
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= byte_out;
                        m_tlast_reg  <= (frame_reg == FR_LO) && (sub_reg == SUB_LOW);
                        if (sub_reg == SUB_LOW)
                        begin
                            sub_reg   <= SUB_SYNC;
                            frame_reg <= frame_reg + 1'b1;
                            if (frame_reg == FR_LO)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### src/line_plot_to_lcd_bitmap.sv
// Line plot to LCD bitmap: top level with configuration registers, front end
// and back end. Depends on lpl_pkg, lpl_front and lpl_back.
`timescale 1ns / 1ps

// The block holds one row position per plot column and turns it into bytes
// for a serial LCD link. A plot beat (tuser = 0) refills every column from
// the slope and intercept registers: column i gets 63 - ((i-63)*m + b + 31)
// modulo 256, with anything off screen parked on the x axis row. It walks
// one column per cycle and sends nothing out. A render beat (tuser = 1)
// reads the 16 positions of one column group in a single memory access,
// builds two bitmap bytes, and sends four frames of three bytes each
// (vertical address, horizontal address, two data bytes), 12 output beats
// with tlast on the final one. A render reads the store, builds the bytes
// and then sends the beats, which a stalled output holds back. The engine
// works on one item at a time; a two-entry command queue in front of it
// keeps accepting beats while it is busy, until both entries are full.
// After reset every position reads as zero; there is no clearing pass.
// Write slope and intercept only while the block is idle.
module line_plot_to_lcd_bitmap #(
    parameter int COLUMNS = 128,
    parameter int ROWS    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] column_group, [8:3] row, [15:9] zero
    input  logic        s_tuser,   // [0] kind
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] serial_byte
    output logic        m_tlast,
    // Configuration writes
    input  logic        cfg_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import lpl_pkg::*;

    logic [7:0] slope_reg;
    logic [7:0] intercept_reg;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;

    // Hold the line coefficients; the user must write them only between items, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slope_reg     <= '0;
            intercept_reg <= '0;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                REG_SLOPE:     slope_reg     <= cfg_data;
                REG_INTERCEPT: intercept_reg <= cfg_data;
            endcase
        end
    end

    // Accept and queue beats
    lpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Regenerate positions or render rows, one command at a time
    lpl_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .slope     (slope_reg),
        .intercept (intercept_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
